@@ src/cssvf_pkg.sv @@
package cssvf_pkg;

   localparam int CHAN_W     = 4;
   localparam int OUT_W      = 23;
   localparam int DATA_W     = 32;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 17;
   localparam int COEF_W     = 16;
   localparam int DAMP_W     = 17;
   localparam int WEIGHT_W   = 17;
   localparam int STAGE_W    = 2;

   // shared multiplier: Q-format coefficient by a 32-bit state value
   localparam int MUL_A_W = 18;
   localparam int MUL_B_W = DATA_W;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = MUL_P_W + 1;
   localparam int RND_W   = ACC_W - 16;
   localparam int SUM_W   = DATA_W + 4;

   localparam logic [WEIGHT_W-1:0] ONE_Q16        = 17'd65536;
   localparam logic [WEIGHT_W-1:0] EDGE_LOW       = 17'd28180;
   localparam logic [WEIGHT_W-1:0] EDGE_DRY_START = 17'd30802;
   localparam logic [WEIGHT_W-1:0] EDGE_DRY_END   = 17'd34734;
   localparam logic [WEIGHT_W-1:0] EDGE_HIGH      = 17'd37356;

   // t = u * 65536 / 2622 = u * 32768 / 1311, exact for u < 2622 with a 23-bit shift
   localparam int FADE_SPAN  = 2622;
   localparam int FADE_SHIFT = 23;
   localparam int FADE_U_W   = 12;
   localparam int FADE_P_W   = 40;
   localparam logic [FADE_P_W-1:0] FADE_RECIP =
      40'(((64'd1 << (FADE_SHIFT + 15)) + 64'(FADE_SPAN / 2) - 64'd1) / 64'(FADE_SPAN / 2));

   localparam logic signed [OUT_W-1:0] VOLT_LIMIT = 23'sd2621440;

   // stability limit on the coefficient, by stage count minus one
   localparam logic [COEF_W-1:0] COEF_LIMIT [4] = '{16'd62259, 16'd49152, 16'd42598, 16'd36045};

   localparam logic [DAMP_W-1:0]     DAMP_RESET   = 17'd92696;
   localparam logic [2:0]            STAGES_RESET = 3'd1;
   localparam logic [WEIGHT_W-1:0]   MORPH_RESET  = 17'd32768;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FREQ_COEF   = 4'd0,
      CSR_DAMPING     = 4'd1,
      CSR_STAGE_COUNT = 4'd2,
      CSR_MORPH       = 4'd3
   } cssvf_csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_DAMP,
      ST_HIGH,
      ST_FHIGH,
      ST_BAND,
      ST_FBAND,
      ST_LOW,
      ST_MIX_LO,
      ST_MIX_DRY,
      ST_MIX_HI,
      ST_MIX_SUM,
      ST_EMIT
   } cssvf_state_type;

   typedef struct packed {
      logic [COEF_W-1:0]   f;
      logic                f_zero;
      logic [DAMP_W-1:0]   d;
      logic [WEIGHT_W-1:0] w_low;
      logic [WEIGHT_W-1:0] w_dry;
      logic [WEIGHT_W-1:0] w_high;
      logic [STAGE_W-1:0]  last_stage;
   } cssvf_coef_type;

   typedef struct packed {
      logic rd;
      logic wr;
   } cssvf_store_ctl_type;

   // scale by 2^-16, round half up
   function automatic logic signed [RND_W-1:0] round_q16(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] s;
      s = v + ACC_W'(32768);
      return RND_W'(s >>> 16);
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(32'sh7fff_ffff);
      lo = -hi - SUM_W'(1);
      if (v > hi) begin
         return 32'sh7fff_ffff;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return DATA_W'(v);
   endfunction

   function automatic logic signed [OUT_W-1:0] clamp_volt(input logic signed [RND_W-1:0] v);
      if (v > RND_W'(VOLT_LIMIT)) begin
         return VOLT_LIMIT;
      end else if (v < -RND_W'(VOLT_LIMIT)) begin
         return -VOLT_LIMIT;
      end
      return OUT_W'(v);
   endfunction

endpackage

@@ src/cssvf_ifs.sv @@
interface cssvf_req_if #(parameter int SAMPLE_WIDTH = 24) ();
   import cssvf_pkg::*;

   logic                           valid;
   logic                           ready;
   logic [CHAN_W-1:0]              channel;
   logic signed [SAMPLE_WIDTH-1:0] left_in;
   logic signed [SAMPLE_WIDTH-1:0] right_in;

   modport source (output valid, channel, left_in, right_in, input ready);
   modport sink (input valid, channel, left_in, right_in, output ready);
endinterface

interface cssvf_rsp_if ();
   import cssvf_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CHAN_W-1:0]       out_channel;
   logic signed [OUT_W-1:0] left_out;
   logic signed [OUT_W-1:0] right_out;

   modport source (output valid, out_channel, left_out, right_out, input ready);
   modport sink (input valid, out_channel, left_out, right_out, output ready);
endinterface

interface cssvf_csr_if ();
   import cssvf_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ src/cascaded_svf_dj_filter_unit.sv @@
// Cascaded state-variable filter for up to 16 poly channels of stereo audio. Each request beat
// carries one channel's left/right pair; each side runs through 1..MAX_STAGES Chamberlin SVF
// stages (stage count from CSR 2, 0 acts as 1) whose low/band state sits in a 2*CHANNELS*
// MAX_STAGES entry RAM, then the last stage's lowpass, the dry input and the highpass are
// crossfaded by the morph CSR and clamped to +-10 V (Q5.18). CSR 0 is the Q0.16 coefficient
// (clamped by stage count), CSR 1 damping (Q1.16), CSR 3 morph; write them only while idle.
// Channels at or above CHANNELS alias onto channel modulo CHANNELS. Each item runs seven steps
// per stage per side plus five mix steps per side around the single shared multiplier, with
// the request side not ready meanwhile. A finished result waits in an output register. The
// state RAM has per-entry valid flags cleared by reset, so there is no clearing pass.
module cascaded_svf_dj_filter_unit #(
   parameter int CHANNELS     = 16,
   parameter int MAX_STAGES   = 4,
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic       clock,
   input  logic       reset,
   cssvf_req_if.sink  req_bus,
   cssvf_rsp_if.source rsp_bus,
   cssvf_csr_if.sink  csr_bus
);
   import cssvf_pkg::*;

   localparam int DEPTH = CHANNELS * MAX_STAGES * 2;
   localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;

   cssvf_state_type     state_ff;
   cssvf_state_type     state_in;
   cssvf_coef_type      coef;
   cssvf_store_ctl_type store_ctl;

   logic [CHAN_W-1:0]  chan_wrap [16];
   logic [CHAN_W-1:0]  chan_ff;
   logic [CHAN_W-1:0]  wrap_ff;
   logic               side_ff;
   logic [STAGE_W-1:0] stage_ff;
   logic [AW-1:0]      addr;

   logic signed [SAMPLE_WIDTH-1:0] left_s;
   logic signed [SAMPLE_WIDTH-1:0] right_s;
   logic signed [DATA_W-1:0] dry_l_ff;
   logic signed [DATA_W-1:0] dry_r_ff;
   logic signed [DATA_W-1:0] x_ff;
   logic signed [DATA_W-1:0] low_ff;
   logic signed [DATA_W-1:0] band_ff;
   logic signed [DATA_W-1:0] high_ff;
   logic signed [DATA_W-1:0] rd_low;
   logic signed [DATA_W-1:0] rd_band;
   logic signed [DATA_W-1:0] low_src;
   logic signed [DATA_W-1:0] band_src;
   logic signed [DATA_W-1:0] low_next;
   logic signed [RND_W-1:0]  prod_rnd;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [OUT_W-1:0]  mix_out;
   logic signed [OUT_W-1:0]  out_l_ff;

   logic                      mul_en;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] prod;

   logic                    req_ready;
   logic                    accept;
   logic                    slot_free;
   logic                    load_rsp;
   logic                    rsp_valid_ff;
   logic [CHAN_W-1:0]       rsp_chan_ff;
   logic signed [OUT_W-1:0] rsp_left_ff;
   logic signed [OUT_W-1:0] rsp_right_ff;

   for (genvar g = 0; g < 16; g++) begin : g_wrap
      assign chan_wrap[g] = CHAN_W'(g % CHANNELS);
   end

   cssvf_coef #(.MAX_STAGES(MAX_STAGES)) u_coef (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .coef    (coef)
   );

   cssvf_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (store_ctl),
      .addr    (addr),
      .wr_low  (low_next),
      .wr_band (band_ff),
      .rd_low  (rd_low),
      .rd_band (rd_band)
   );

   cssvf_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .p     (prod)
   );

   assign left_s   = req_bus.left_in;
   assign right_s  = req_bus.right_in;
   assign accept   = req_bus.valid && req_ready;
   assign addr     = AW'((32'(wrap_ff) * 32'(MAX_STAGES) + 32'(stage_ff)) * 32'd2 + 32'(side_ff));
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   // zero coefficient pins the visited stages at zero
   assign low_src  = coef.f_zero ? '0 : rd_low;
   assign band_src = coef.f_zero ? '0 : rd_band;
   assign prod_rnd = round_q16(ACC_W'(prod));
   assign low_next = sat32(SUM_W'(low_ff) + SUM_W'(prod_rnd));
   assign mix_out  = clamp_volt(round_q16(acc_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (accept) state_in = ST_READ;
         ST_READ:    state_in = ST_DAMP;
         ST_DAMP:    state_in = ST_HIGH;
         ST_HIGH:    state_in = ST_FHIGH;
         ST_FHIGH:   state_in = ST_BAND;
         ST_BAND:    state_in = ST_FBAND;
         ST_FBAND:   state_in = ST_LOW;
         ST_LOW:     state_in = (stage_ff == coef.last_stage) ? ST_MIX_LO : ST_READ;
         ST_MIX_LO:  state_in = ST_MIX_DRY;
         ST_MIX_DRY: state_in = ST_MIX_HI;
         ST_MIX_HI:  state_in = ST_MIX_SUM;
         ST_MIX_SUM: state_in = ST_EMIT;
         ST_EMIT: begin
            priority if (!side_ff) begin
               state_in = ST_READ;
            end else if (slot_free) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs: handshake, RAM strobes, multiplier operands
   always_comb begin
      req_ready    = 1'b0;
      store_ctl.rd = 1'b0;
      store_ctl.wr = 1'b0;
      load_rsp     = 1'b0;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_READ:  store_ctl.rd = 1'b1;
         ST_DAMP: begin
            mul_en = 1'b1;
            mul_a  = $signed({1'b0, coef.d});
            mul_b  = band_src;
         end
         ST_FHIGH: begin
            mul_en = 1'b1;
            mul_a  = $signed({2'b00, coef.f});
            mul_b  = high_ff;
         end
         ST_FBAND: begin
            mul_en = 1'b1;
            mul_a  = $signed({2'b00, coef.f});
            mul_b  = band_ff;
         end
         ST_LOW:   store_ctl.wr = 1'b1;
         ST_MIX_LO: begin
            mul_en = 1'b1;
            mul_a  = $signed({1'b0, coef.w_low});
            mul_b  = low_ff;
         end
         ST_MIX_DRY: begin
            mul_en = 1'b1;
            mul_a  = $signed({1'b0, coef.w_dry});
            mul_b  = side_ff ? dry_r_ff : dry_l_ff;
         end
         ST_MIX_HI: begin
            mul_en = 1'b1;
            mul_a  = $signed({1'b0, coef.w_high});
            mul_b  = high_ff;
         end
         ST_EMIT:  load_rsp = side_ff && slot_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         side_ff  <= 1'b0;
         stage_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            side_ff  <= 1'b0;
            stage_ff <= '0;
         end else if (state_ff == ST_LOW && stage_ff != coef.last_stage) begin
            stage_ff <= stage_ff + STAGE_W'(1);
         end else if (state_ff == ST_EMIT && !side_ff) begin
            side_ff  <= 1'b1;
            stage_ff <= '0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               chan_ff  <= req_bus.channel;
               wrap_ff  <= chan_wrap[req_bus.channel];
               dry_l_ff <= DATA_W'(left_s);
               dry_r_ff <= DATA_W'(right_s);
               x_ff     <= DATA_W'(left_s);
            end
         end
         ST_DAMP: begin
            low_ff  <= low_src;
            band_ff <= band_src;
         end
         ST_HIGH:    high_ff <= sat32(SUM_W'(x_ff) - SUM_W'(low_ff) - SUM_W'(prod_rnd));
         ST_BAND:    band_ff <= sat32(SUM_W'(band_ff) + SUM_W'(prod_rnd));
         ST_LOW: begin
            low_ff <= low_next;
            x_ff   <= high_ff;
         end
         ST_MIX_DRY: acc_ff <= ACC_W'(prod);
         ST_MIX_HI,
         ST_MIX_SUM: acc_ff <= acc_ff + ACC_W'(prod);
         ST_EMIT: begin
            if (!side_ff) begin
               out_l_ff <= mix_out;
               x_ff     <= dry_r_ff;
            end
         end
         default: ;
      endcase
   end

   // result register, frees the sequencer while a beat waits downstream
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_chan_ff  <= chan_ff;
         rsp_left_ff  <= out_l_ff;
         rsp_right_ff <= mix_out;
      end
   end

   assign req_bus.ready       = req_ready;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_channel = rsp_chan_ff;
   assign rsp_bus.left_out    = rsp_left_ff;
   assign rsp_bus.right_out   = rsp_right_ff;
endmodule

@@ src/cssvf_mul.sv @@
module cssvf_mul (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic signed [cssvf_pkg::MUL_A_W-1:0] a,
   input  logic signed [cssvf_pkg::MUL_B_W-1:0] b,
   output logic signed [cssvf_pkg::MUL_P_W-1:0] p
);
   import cssvf_pkg::*;

   logic signed [MUL_P_W-1:0] prod_ff;
   logic signed [MUL_P_W-1:0] prod_in;

   assign prod_in = MUL_P_W'(a) * MUL_P_W'(b);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign p = prod_ff;
endmodule

@@ src/cssvf_coef.sv @@
module cssvf_coef #(
   parameter int MAX_STAGES = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   cssvf_csr_if.sink                 csr_bus,
   output cssvf_pkg::cssvf_coef_type coef
);
   import cssvf_pkg::*;

   logic [COEF_W-1:0]   freq_ff;
   logic [DAMP_W-1:0]   damp_ff;
   logic [2:0]          stages_ff;
   logic [WEIGHT_W-1:0] morph_ff;
   cssvf_coef_type      coef_ff;
   cssvf_coef_type      coef_in;

   logic [STAGE_W-1:0]  stages_m1;
   logic [COEF_W-1:0]   limit;
   logic [WEIGHT_W-1:0] m;
   logic [FADE_U_W-1:0] fade_u;
   logic [FADE_P_W-1:0] fade_prod;
   logic [WEIGHT_W-1:0] fade_t;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff   <= '0;
         damp_ff   <= DAMP_RESET;
         stages_ff <= STAGES_RESET;
         morph_ff  <= MORPH_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_FREQ_COEF:   freq_ff   <= csr_bus.data[COEF_W-1:0];
            CSR_DAMPING:     damp_ff   <= csr_bus.data[DAMP_W-1:0];
            CSR_STAGE_COUNT: stages_ff <= csr_bus.data[2:0];
            CSR_MORPH:       morph_ff  <= csr_bus.data[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (stages_ff == 3'd0) begin
         stages_m1 = '0;
      end else if (stages_ff > 3'(MAX_STAGES)) begin
         stages_m1 = STAGE_W'(MAX_STAGES - 1);
      end else begin
         stages_m1 = STAGE_W'(stages_ff - 3'd1);
      end
      limit = COEF_LIMIT[stages_m1];

      m = (morph_ff > ONE_Q16) ? ONE_Q16 : morph_ff;
      fade_u = (m < EDGE_DRY_START) ? FADE_U_W'(m - EDGE_LOW) : FADE_U_W'(m - EDGE_DRY_END);
      fade_prod = FADE_P_W'(fade_u) * FADE_RECIP;
      fade_t = WEIGHT_W'(fade_prod >> FADE_SHIFT);

      coef_in.f          = (freq_ff > limit) ? limit : freq_ff;
      coef_in.f_zero     = (freq_ff == '0);
      coef_in.d          = damp_ff;
      coef_in.last_stage = stages_m1;
      coef_in.w_low      = '0;
      coef_in.w_dry      = '0;
      coef_in.w_high     = '0;
      priority if (m <= EDGE_LOW) begin
         coef_in.w_low  = ONE_Q16;
      end else if (m < EDGE_DRY_START) begin
         coef_in.w_low  = ONE_Q16 - fade_t;
         coef_in.w_dry  = fade_t;
      end else if (m < EDGE_DRY_END) begin
         coef_in.w_dry  = ONE_Q16;
      end else if (m < EDGE_HIGH) begin
         coef_in.w_dry  = ONE_Q16 - fade_t;
         coef_in.w_high = fade_t;
      end else begin
         coef_in.w_high = ONE_Q16;
      end
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
   end

   assign coef = coef_ff;
endmodule

@@ src/cssvf_store.sv @@
module cssvf_store #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cssvf_pkg::cssvf_store_ctl_type      ctl,
   input  logic [AW-1:0]                       addr,
   input  logic signed [cssvf_pkg::DATA_W-1:0] wr_low,
   input  logic signed [cssvf_pkg::DATA_W-1:0] wr_band,
   output logic signed [cssvf_pkg::DATA_W-1:0] rd_low,
   output logic signed [cssvf_pkg::DATA_W-1:0] rd_band
);
   import cssvf_pkg::*;

   logic [2*DATA_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]    valid_ff;
   logic [2*DATA_W-1:0] rd_ff;
   logic                rd_vld_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         mem[addr] <= {wr_low, wr_band};
      end
      if (ctl.rd) begin
         rd_ff     <= mem[addr];
         rd_vld_ff <= valid_ff[addr];
      end
   end

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.wr) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   assign rd_low  = rd_vld_ff ? rd_ff[2*DATA_W-1:DATA_W] : '0;
   assign rd_band = rd_vld_ff ? rd_ff[DATA_W-1:0] : '0;
endmodule

@@ src/cssvf_checker.sv @@
module cssvf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [cssvf_pkg::OUT_W-1:0]  left_out,
   input logic signed [cssvf_pkg::OUT_W-1:0]  right_out
);
   import cssvf_pkg::*;

   logic req_beat;

   assign req_beat = req_valid && req_ready;

   // a stalled result beat is held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (left_out <= VOLT_LIMIT) && (left_out >= -VOLT_LIMIT)
                 && (right_out <= VOLT_LIMIT) && (right_out >= -VOLT_LIMIT))
      else $error("result outside +-10 V");

   // one item at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_ready)
      else $error("request taken while busy");

   // a result never shows up right behind a request beat
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_beat))
      else $error("result too early");
endmodule

bind cascaded_svf_dj_filter_unit cssvf_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .left_out  (rsp_bus.left_out),
   .right_out (rsp_bus.right_out)
);
